>>> design/fpl_pkg.sv
// shared types and constants of the framed parameter link
package fpl_pkg;

	// item kinds
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_PB_END = 2'd2;

	// link modes
	localparam logic [1:0] MODE_LIVE     = 2'd0;
	localparam logic [1:0] MODE_RECORD   = 2'd1;
	localparam logic [1:0] MODE_PLAYBACK = 2'd2;

	// word index field wide enough for the largest parameter or command table
	localparam int IDX_W = 6;
	localparam logic [IDX_W-1:0] MODE_CMD_IDX = IDX_W'(2);

	// operation queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_PARAM_WR = 2'd0,
		OP_CMD_WR   = 2'd1,
		OP_TICK     = 2'd2,
		OP_PB_END   = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [31:0]      value;
	} op_entry_t;

	typedef struct packed {
		logic       full;
		logic       empty;
	} queue_ctl_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [2:0] confirm_number;
		logic [31:0]       confirm_value;
		logic [1:0]        link_mode;
	} result_t;

endpackage

>>> design/fpl_front.sv
// front end: receive window, frame detection and item classification
module fpl_front #(
	parameter int PARAM_COUNT   = 3,
	parameter int COMMAND_COUNT = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  fpl_pkg::in_item_t item,
	output logic              push,
	output fpl_pkg::op_entry_t entry
);
	import fpl_pkg::*;

	localparam int WIN_LEN = 10;
	localparam int FILL_W  = $clog2(WIN_LEN + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);
	localparam logic [7:0] FRAME_START = 8'd7;
	localparam logic [7:0] FRAME_STOP  = 8'd8;

	logic [7:0]        win_q [WIN_LEN];
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        win_n [WIN_LEN];
	logic [FILL_W-1:0] fill_n;
	logic              frame;
	logic [31:0]       raw_num;
	logic [31:0]       raw_val;
	logic              param_ok;
	logic              cmd_ok;
	logic              is_byte;

	assign is_byte = (item.kind == KIND_BYTE);

	always_comb begin
		win_n  = win_q;
		fill_n = fill_q;
		if (fill_q == FILL_FULL) begin
			// drop oldest byte
			for (int i = 0; i < WIN_LEN - 1; i++) begin
				win_n[i] = win_q[i + 1];
			end
			win_n[WIN_LEN-1] = item.rx_byte;
		end else begin
			win_n[fill_q] = item.rx_byte;
			fill_n        = fill_q + FILL_W'(1);
		end
	end

	assign frame = (fill_n == FILL_FULL) && (win_n[0] == FRAME_START)
		&& (win_n[WIN_LEN-1] == FRAME_STOP);

	assign raw_num = {win_n[4], win_n[3], win_n[2], win_n[1]};
	assign raw_val = {win_n[8], win_n[7], win_n[6], win_n[5]};

	assign param_ok = !raw_num[31] && (raw_num < 32'(PARAM_COUNT));
	assign cmd_ok   = raw_num[31] && (raw_num >= 32'(-COMMAND_COUNT));

	always_comb begin
		entry.value = raw_val;
		entry.idx   = param_ok ? raw_num[IDX_W-1:0] : ~raw_num[IDX_W-1:0];
		entry.op    = OP_TICK;
		push        = 1'b0;
		case (item.kind)
			KIND_BYTE: begin
				entry.op = param_ok ? OP_PARAM_WR : OP_CMD_WR;
				push     = accept && frame && (param_ok || cmd_ok);
			end
			KIND_TICK: begin
				entry.op = OP_TICK;
				push     = accept;
			end
			KIND_PB_END: begin
				entry.op = OP_PB_END;
				push     = accept;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept && is_byte) begin
			if (frame) begin
				fill_q <= '0;
				for (int i = 0; i < WIN_LEN; i++) begin
					win_q[i] <= '0;
				end
			end else begin
				fill_q <= fill_n;
				win_q  <= win_n;
			end
		end
	end

endmodule

>>> design/fpl_queue.sv
// short operation queue between front and back
module fpl_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                pop,
	input  fpl_pkg::op_entry_t  wr_entry,
	output fpl_pkg::op_entry_t  rd_entry,
	output fpl_pkg::queue_ctl_t ctl
);
	import fpl_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	op_entry_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign ctl.full  = (count_q == CNT_FULL);
	assign ctl.empty = (count_q == '0);
	assign do_push   = push && !ctl.full;
	assign do_pop    = pop && !ctl.empty;
	assign rd_entry  = slot_q[head_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[tail_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
			end
			if (do_pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/fpl_back.sv
// back end: word store, mode control and rotating report
module fpl_back #(
	parameter int PARAM_COUNT   = 3,
	parameter int COMMAND_COUNT = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fpl_pkg::queue_ctl_t ctl,
	input  fpl_pkg::op_entry_t  head,
	output logic                pop,
	output logic                strobe,
	output fpl_pkg::result_t    result
);
	import fpl_pkg::*;

	localparam int PW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
	localparam int CW = $clog2(COMMAND_COUNT);
	localparam int MAXC = (PARAM_COUNT > COMMAND_COUNT) ? PARAM_COUNT : COMMAND_COUNT;
	localparam int RW = $clog2(MAXC) + 1;
	localparam logic signed [RW-1:0] ROT_LAST  = RW'(PARAM_COUNT - 1);
	localparam logic signed [RW-1:0] ROT_FIRST = RW'(-COMMAND_COUNT);
	localparam logic [31:0] WORD_ONE  = 32'h3F80_0000;
	localparam logic [31:0] WORD_HALF = 32'h3F00_0000;

	logic [31:0]           param_q [PARAM_COUNT];
	logic [31:0]           cmd_q   [COMMAND_COUNT];
	logic [1:0]            mode_q;
	logic signed [RW-1:0]  rot_q;
	logic                  strobe_q;
	result_t               result_q;
	logic                  tick_out;
	logic [31:0]           rot_word;
	logic [CW-1:0]         cmd_idx;
	logic [31:0]           cmd_old;

	assign pop     = !ctl.empty;
	assign cmd_idx = head.idx[CW-1:0];
	assign cmd_old = cmd_q[cmd_idx];

	assign tick_out = pop && (head.op == OP_TICK) && (mode_q != MODE_PLAYBACK);
	assign rot_word = rot_q[RW-1] ? cmd_q[~rot_q[CW-1:0]] : param_q[rot_q[PW-1:0]];

	always_ff @(posedge clk) begin
		if (tick_out) begin
			result_q.confirm_number <= rot_q[2:0];
			result_q.confirm_value  <= rot_word;
			result_q.link_mode      <= mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PARAM_COUNT; i++) begin
				param_q[i] <= (i < 2) ? WORD_ONE : ((i == 2) ? WORD_HALF : '0);
			end
			for (int i = 0; i < COMMAND_COUNT; i++) begin
				cmd_q[i] <= '0;
			end
			mode_q   <= MODE_LIVE;
			rot_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= tick_out;
			if (pop) begin
				case (head.op)
					OP_PARAM_WR: begin
						param_q[head.idx[PW-1:0]] <= head.value;
					end
					OP_CMD_WR: begin
						if (head.idx == MODE_CMD_IDX && head.value != cmd_old) begin
							if (head.value == 32'd1) begin
								mode_q <= MODE_RECORD;
							end else if (head.value == 32'd0) begin
								mode_q <= MODE_PLAYBACK;
							end
						end
						cmd_q[cmd_idx] <= head.value;
					end
					OP_TICK: begin
						if (mode_q != MODE_PLAYBACK) begin
							rot_q <= (rot_q == ROT_LAST) ? ROT_FIRST : rot_q + RW'(1);
						end
					end
					OP_PB_END: begin
						if (mode_q == MODE_PLAYBACK) begin
							mode_q <= MODE_LIVE;
						end
					end
					default: begin
						mode_q <= mode_q;
					end
				endcase
			end
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

>>> design/framed_parameter_link.sv
// top level of the framed parameter link
//
// framed parameter link: an item is taken on a clock edge with start high and
// busy low; kind selects a received link byte, a loop tick or the end of
// playback. bytes collect in a ten-byte window; a window holding start byte 7,
// eight payload bytes (little-endian signed word number, then a 32-bit value)
// and stop byte 8 writes a parameter word (number >= 0) or a command word
// (number < 0), then the window clears. writing command -3 with a changed value
// of 1 or 0 switches to recording or playback; an end-of-playback item returns
// to live. every tick outside playback reports one stored word with the
// current mode on result, marked by strobe for a single cycle, and steps the
// reported index from -COMMAND_COUNT up to PARAM_COUNT-1 and around again.
// out-of-range numbers change nothing. while busy is low, one item per clock
// is taken: the front end classifies it in its accept cycle and drops it into
// a two-entry queue, the back end executes one queued item per clock, and a
// tick's report passes the queue and then the strobe register. the back end
// drains the queue every cycle, so busy stays low in normal operation. result
// cannot be held off by the receiver; sample it whenever strobe is high
module framed_parameter_link #(
	parameter int PARAM_COUNT   = 3,
	parameter int COMMAND_COUNT = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fpl_pkg::in_item_t item,
	output logic              strobe,
	output fpl_pkg::result_t  result
);
	import fpl_pkg::*;

	logic       accept;
	logic       push;
	logic       pop;
	op_entry_t  push_entry;
	op_entry_t  head_entry;
	queue_ctl_t qctl;

	// an item is taken whenever start is high and the queue has room
	assign busy   = qctl.full;
	assign accept = start && !busy;

	// window handling and item classification
	fpl_front #(
		.PARAM_COUNT   (PARAM_COUNT),
		.COMMAND_COUNT (COMMAND_COUNT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.push   (push),
		.entry  (push_entry)
	);

	// decouples classification from execution
	fpl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.wr_entry (push_entry),
		.rd_entry (head_entry),
		.ctl      (qctl)
	);

	// word store, mode and rotating report
	fpl_back #(
		.PARAM_COUNT   (PARAM_COUNT),
		.COMMAND_COUNT (COMMAND_COUNT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (qctl),
		.head   (head_entry),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

>>> dv/fpl_check_pkg.sv
`timescale 1ns / 100ps
// scoreboard class that predicts and checks framed parameter link results
package fpl_check_pkg;
	import fpl_pkg::*;

	localparam int N_PARAMS = 3;
	localparam int N_COMMANDS = 3;
	localparam int WIN_LEN = 10;
	localparam logic [7:0] START_BYTE = 8'd7;
	localparam logic [7:0] STOP_BYTE = 8'd8;
	localparam int MODE_CMD_NUMBER = -3;
	localparam logic [31:0] WORD_ONE = 32'h3F80_0000;
	localparam logic [31:0] WORD_HALF = 32'h3F00_0000;
	localparam int MAX_REPORTS = 10;

	class link_scoreboard;
		logic [7:0] window [WIN_LEN];
		int unsigned fill;
		logic [31:0] params [N_PARAMS];
		logic [31:0] commands [N_COMMANDS];
		logic [1:0] mode;
		int rot_idx;
		result_t pending_reports [$];
		int unsigned reports_checked;
		int unsigned errors;
		int unsigned frames_seen;
		int unsigned mode_switches;

		function new();
			foreach (window[i]) window[i] = '0;
			fill = 0;
			foreach (params[i]) params[i] = (i < 2) ? WORD_ONE : (i == 2) ? WORD_HALF : '0;
			foreach (commands[i]) commands[i] = '0;
			mode = MODE_LIVE;
			rot_idx = 0;
			reports_checked = 0;
			errors = 0;
			frames_seen = 0;
			mode_switches = 0;
		endfunction

		// byte into the window, frame applied as soon as it sits complete
		function void shift_in(logic [7:0] b);
			logic [31:0] num_raw;
			logic [31:0] value;
			int num;
			int slot;
			if (fill >= WIN_LEN) begin
				for (int i = 0; i < WIN_LEN - 1; i++)
					window[i] = window[i + 1];
				fill = WIN_LEN - 1;
			end
			window[fill] = b;
			fill++;
			if (fill == WIN_LEN && window[0] == START_BYTE
					&& window[WIN_LEN - 1] == STOP_BYTE) begin
				num_raw = {window[4], window[3], window[2], window[1]};
				value = {window[8], window[7], window[6], window[5]};
				num = $signed(num_raw);
				frames_seen++;
				if (num >= 0) begin
					if (num < N_PARAMS)
						params[num] = value;
				end else if (num >= -N_COMMANDS) begin
					slot = -num - 1;
					if (num == MODE_CMD_NUMBER && value != commands[slot]) begin
						if (value == 32'd1) begin
							mode = MODE_RECORD;
							mode_switches++;
						end else if (value == 32'd0) begin
							mode = MODE_PLAYBACK;
							mode_switches++;
						end
					end
					commands[slot] = value;
				end
				foreach (window[i]) window[i] = '0;
				fill = 0;
			end
		endfunction

		function void note_item(in_item_t it);
			result_t r;
			case (it.kind)
				KIND_BYTE: shift_in(it.rx_byte);
				KIND_PB_END: begin
					if (mode == MODE_PLAYBACK)
						mode = MODE_LIVE;
				end
				KIND_TICK: begin
					if (mode != MODE_PLAYBACK) begin
						r.confirm_number = 3'(rot_idx);
						r.confirm_value = (rot_idx < 0) ? commands[-rot_idx - 1] : params[rot_idx];
						r.link_mode = mode;
						pending_reports.push_back(r);
						rot_idx++;
						if (rot_idx >= N_PARAMS)
							rot_idx = -N_COMMANDS;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_reports.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result number %0d value %h mode %0d", $time,
						got.confirm_number, got.confirm_value, got.link_mode);
				return;
			end
			want = pending_reports.pop_front();
			reports_checked++;
			if (got.confirm_number !== want.confirm_number
					|| got.confirm_value !== want.confirm_value
					|| got.link_mode !== want.link_mode) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display({"%0t: result %0d mismatch: number exp %0d got %0d, ",
						"value exp %h got %h, mode exp %0d got %0d"},
						$time, reports_checked, want.confirm_number, got.confirm_number,
						want.confirm_value, got.confirm_value, want.link_mode, got.link_mode);
			end
		endfunction
	endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// testbench top: random and directed byte, tick and playback items against a scoreboard
module tb_top;
	import fpl_pkg::*;
	import fpl_check_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1800;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {FLAW_NONE, FLAW_STOP, FLAW_CUT, FLAW_START} frame_flaw_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic strobe;
	result_t result;

	link_scoreboard sb = new();
	int unsigned items_sent = 0;
	int unsigned ticks_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned stall_cycles = 0;
	bit idling_on = 1'b1;

	framed_parameter_link u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// results cannot be held off, so every strobe cycle is checked
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(result);
	end

	// watchdog: too long with nothing taken and nothing reported ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d quiet cycles, %0d results outstanding", stall_cycles,
					sb.pending_reports.size());
				$display("framed_parameter_link test failed");
				$finish;
			end
		end
	end

	// one item: optional idle gap, then hold start until an edge with busy low
	// start is only dropped when a gap is taken, so back-to-back items keep it high
	// idle gaps ahead of about one item in five keep the input idle for roughly
	// a third of the cycles
	task automatic send(logic [1:0] kind, logic [7:0] b);
		int gap;
		if (idling_on && $urandom_range(99) < 19) begin
			gap = $urandom_range(4, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= {kind, b};
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(item);
		items_sent++;
		if (kind == KIND_TICK)
			ticks_sent++;
	endtask

	// start byte, number and value little-endian, stop byte; a flaw breaks the frame
	task automatic send_frame(int num, logic [31:0] value, frame_flaw_t flaw);
		logic [7:0] bytes [10];
		logic [31:0] num_bits;
		int last;
		num_bits = num;
		bytes[0] = START_BYTE;
		for (int i = 0; i < 4; i++) begin
			bytes[1 + i] = num_bits[8*i +: 8];
			bytes[5 + i] = value[8*i +: 8];
		end
		bytes[9] = STOP_BYTE;
		last = 9;
		case (flaw)
			FLAW_STOP: bytes[9] ^= 8'($urandom_range(255, 1));
			FLAW_START: bytes[0] ^= 8'($urandom_range(255, 1));
			FLAW_CUT: last = $urandom_range(8, 1);
			default: ;
		endcase
		for (int i = 0; i <= last; i++)
			send(KIND_BYTE, bytes[i]);
		frames_sent++;
	endtask

	initial begin
		int pick;
		int sel;
		int num;
		logic [31:0] value;
		int unsigned random_start;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: index walk through the wrap, ignored kinds, a frame behind a junk byte
		repeat (3) send(KIND_TICK, 8'h00);
		repeat (3) send(KIND_TICK, 8'hFF);
		send(KIND_UNUSED, 8'hFF);
		send(KIND_PB_END, 8'h00);
		send(KIND_BYTE, 8'hFF);
		send_frame(MODE_CMD_NUMBER, 32'd1, FLAW_NONE);
		send(KIND_TICK, 8'hFF);

		// random: mostly well-formed frames and ticks, some noise and broken frames
		random_start = items_sent;
		while (items_sent < random_start + RANDOM_ITEMS) begin
			// a long stretch with back-to-back items in the middle
			idling_on = !(items_sent >= random_start + 800 && items_sent < random_start + 1200);
			pick = $urandom_range(99);
			if (pick < 40) begin
				sel = $urandom_range(9);
				case (sel)
					0, 1, 2: num = sel;
					3, 4: num = MODE_CMD_NUMBER;
					5: num = -int'($urandom_range(2, 1));
					6: num = N_PARAMS;
					7: num = -N_COMMANDS - 1;
					8: num = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					default: num = $urandom();
				endcase
				if (num == MODE_CMD_NUMBER) begin
					case ($urandom_range(3))
						0: value = 32'd0;
						1: value = 32'd1;
						2: value = $urandom_range(3);
						default: value = $urandom();
					endcase
				end else begin
					case ($urandom_range(7))
						6: value = 32'd0;
						7: value = 32'hFFFF_FFFF;
						default: value = $urandom();
					endcase
				end
				// junk ahead of the frame makes the window slide
				if ($urandom_range(99) < 30)
					repeat ($urandom_range(3, 1)) send(KIND_BYTE, 8'($urandom()));
				send_frame(num, value, FLAW_NONE);
			end else if (pick < 48) begin
				send_frame($urandom_range(5) - 3, $urandom(),
					frame_flaw_t'($urandom_range(FLAW_START, FLAW_STOP)));
			end else if (pick < 78) begin
				send(KIND_TICK, 8'($urandom()));
			end else if (pick < 86) begin
				send(KIND_PB_END, 8'($urandom()));
			end else if (pick < 89) begin
				send(KIND_UNUSED, 8'($urandom()));
			end else begin
				send(KIND_BYTE, 8'($urandom()));
			end
		end
		start <= 1'b0;

		// drain: the watchdog bounds this wait
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items: %0d ticks, %0d frame attempts", items_sent, ticks_sent,
			frames_sent);
		$display("checked %0d results, %0d frames recognized, %0d mode changes, %0d errors",
			sb.reports_checked, sb.frames_seen, sb.mode_switches, sb.errors);
		if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
			$display("framed_parameter_link test passed");
		end else begin
			$display("framed_parameter_link test failed");
		end
		$finish;
	end

endmodule
